/* sv/spmq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_pkg: shared types and constants of the strict priority queue
// Sizes of the level FIFOs, derived widths and the command word that
// passes from the front end to the back end.
// ----------------------------------------------------------------------------
package spmq_pkg;

  localparam int LEVELS      = 16;
  localparam int LEVEL_DEPTH = 16;
  localparam int ITEM_WIDTH  = 16;

  // Fixed port widths.
  localparam int PRI_W   = 4;
  localparam int HANDLE_W = 16;
  localparam int COUNT_W = 9;

  localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W    = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CNT_W    = $clog2(LEVEL_DEPTH + 1);
  localparam int ENTRIES  = LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W   = $clog2(ENTRIES);
  localparam int HELD_RAW = $clog2(ENTRIES + 1);
  localparam int HELD_W   = (HELD_RAW > COUNT_W) ? HELD_RAW : COUNT_W;

  // Command queue between front and back end.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef struct packed {
    logic                  wr;        // store the word at addr
    logic                  rd;        // dequeue that returns a word
    logic [ADDR_W-1:0]     addr;
    logic [ITEM_WIDTH-1:0] data;
    logic                  overflow;
    logic [COUNT_W-1:0]    total;
    logic                  empty;
  } cmd_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] inc;
    inc = {1'b0, p} + (PTR_W + 1)'(1);
    if (inc == (PTR_W + 1)'(LEVEL_DEPTH)) begin
      return '0;
    end
    return inc[PTR_W-1:0];
  endfunction

  function automatic logic [ITEM_WIDTH-1:0] to_item(input logic [HANDLE_W-1:0] h);
    logic [63:0] w;
    w = 64'(h);
    return w[ITEM_WIDTH-1:0];
  endfunction

  function automatic logic [HANDLE_W-1:0] from_item(input logic [ITEM_WIDTH-1:0] d);
    logic [63:0] w;
    w = 64'(d);
    return w[HANDLE_W-1:0];
  endfunction

endpackage

/* sv/strict_priority_multilevel_queue.sv */
`timescale 1ns / 1ps
// Each result passes the command queue, then the registered memory read.
// One access per cycle while busy is low; the back end drains one command word every cycle.
// busy rises only when the command queue is full; the receiver cannot stall results.
// Reset (synchronous, active low) empties every level; the item memory is not cleared.
// ----------------------------------------------------------------------------
// strict_priority_multilevel_queue: one FIFO per level, strict priority service
// Enqueue appends to a level, dequeue returns the head of the lowest-numbered
// non-empty level; every access reports the total count and emptiness.
// ----------------------------------------------------------------------------
module strict_priority_multilevel_queue
  import spmq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_operation,
  input  logic [PRI_W-1:0]    in_priority_req,
  input  logic [HANDLE_W-1:0] in_item_in,
  output logic                out_strobe,
  output logic [HANDLE_W-1:0] out_item_out,
  output logic                out_item_valid,
  output logic                out_overflow,
  output logic [COUNT_W-1:0]  out_total_count,
  output logic                out_is_empty
);

  logic acc;
  logic q_full;
  logic q_valid;
  cmd_t front_cmd;
  cmd_t back_cmd;

  assign busy = q_full;
  assign acc  = start && !q_full;

  spmq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .operation    (in_operation),
    .priority_req (in_priority_req),
    .item_in      (in_item_in),
    .cmd          (front_cmd)
  );

  spmq_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_valid),
    .pop_valid (q_valid),
    .pop_cmd   (back_cmd)
  );

  spmq_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (q_valid),
    .cmd             (back_cmd),
    .out_strobe      (out_strobe),
    .out_item_out    (out_item_out),
    .out_item_valid  (out_item_valid),
    .out_overflow    (out_overflow),
    .out_total_count (out_total_count),
    .out_is_empty    (out_is_empty)
  );

  a_result_follows_access: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_strobe)
    else $error("accepted access produced no result two cycles later");

endmodule

/* sv/spmq_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_front: access classification and level bookkeeping
// Holds head, tail and occupancy of every level, picks the level an access
// works on and issues one command word per accepted access.
// ----------------------------------------------------------------------------
module spmq_front
  import spmq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic                operation,
  input  logic [PRI_W-1:0]    priority_req,
  input  logic [HANDLE_W-1:0] item_in,
  output cmd_t                cmd
);

  logic [PTR_W-1:0]  heads_r  [LEVELS];
  logic [PTR_W-1:0]  tails_r  [LEVELS];
  logic [CNT_W-1:0]  counts_r [LEVELS];
  logic [HELD_W-1:0] held_r;
  logic [HELD_W-1:0] held_nxt;

  logic [LEVELS-1:0] nonempty;
  logic [LVL_W-1:0]  enq_lvl;
  logic [LVL_W-1:0]  deq_lvl;
  logic [LVL_W-1:0]  sel_lvl;
  logic              any_ne;
  logic              is_deq;
  logic [CNT_W-1:0]  sel_cnt;
  logic              lvl_full;
  logic              do_enq;
  logic              do_deq;
  logic [PTR_W-1:0]  sel_ptr;
  logic [PTR_W-1:0]  ptr_nxt;

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      nonempty[i] = (counts_r[i] != '0);
    end
  end

  // Lowest-numbered non-empty level wins.
  always_comb begin
    deq_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        deq_lvl = LVL_W'(i);
      end
    end
  end

  // A requested level past the last one saturates to the last.
  always_comb begin
    if (32'(priority_req) >= 32'(LEVELS)) begin
      enq_lvl = LVL_W'(LEVELS - 1);
    end else begin
      enq_lvl = LVL_W'(priority_req);
    end
  end

  assign any_ne   = |nonempty;
  assign is_deq   = (op_t'(operation) == OP_DEQUEUE);
  assign sel_lvl  = is_deq ? deq_lvl : enq_lvl;
  assign sel_cnt  = counts_r[sel_lvl];
  assign lvl_full = (sel_cnt == CNT_W'(LEVEL_DEPTH));
  assign do_enq   = acc && !is_deq && !lvl_full;
  assign do_deq   = acc && is_deq && any_ne;
  assign sel_ptr  = is_deq ? heads_r[sel_lvl] : tails_r[sel_lvl];
  assign ptr_nxt  = ptr_next(sel_ptr);

  always_comb begin
    held_nxt = held_r;
    if (do_enq) begin
      held_nxt = held_r + HELD_W'(1);
    end else if (do_deq) begin
      held_nxt = held_r - HELD_W'(1);
    end
  end

  always_comb begin
    cmd.wr       = do_enq;
    cmd.rd       = do_deq;
    cmd.addr     = ADDR_W'(ADDR_W'(sel_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(sel_ptr));
    cmd.data     = to_item(item_in);
    cmd.overflow = !is_deq && lvl_full;
    cmd.total    = held_nxt[COUNT_W-1:0];
    cmd.empty    = (held_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        heads_r[i]  <= '0;
        tails_r[i]  <= '0;
        counts_r[i] <= '0;
      end
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
      if (do_enq) begin
        tails_r[sel_lvl]  <= ptr_nxt;
        counts_r[sel_lvl] <= sel_cnt + CNT_W'(1);
      end else if (do_deq) begin
        heads_r[sel_lvl]  <= ptr_nxt;
        counts_r[sel_lvl] <= sel_cnt - CNT_W'(1);
      end
    end
  end

  a_overflow_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && cmd.overflow) |=> $stable(held_r))
    else $error("dropped enqueue changed the item count");

  a_enqueue_counts_up: assert property (@(posedge clk) disable iff (!rst_n)
    do_enq |=> (held_r == $past(held_r) + HELD_W'(1)))
    else $error("accepted enqueue did not raise the item count");

  a_empty_matches_levels: assert property (@(posedge clk) disable iff (!rst_n)
    ((held_r == '0) == (nonempty == '0)))
    else $error("item count disagrees with level occupancy");

endmodule

/* sv/spmq_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_fifo: command queue between front and back end
// A short FIFO of command words; full holds off new accesses.
// ----------------------------------------------------------------------------
module spmq_fifo
  import spmq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  cmd_t              slots_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
    end
  end

endmodule

/* sv/spmq_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_back: item store and result register
// Carries out one command word a cycle against the item memory and drives
// the registered result in the cycle after.
// ----------------------------------------------------------------------------
module spmq_back
  import spmq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  cmd_t                cmd,
  output logic                out_strobe,
  output logic [HANDLE_W-1:0] out_item_out,
  output logic                out_item_valid,
  output logic                out_overflow,
  output logic [COUNT_W-1:0]  out_total_count,
  output logic                out_is_empty
);

  logic [ITEM_WIDTH-1:0] mem [ENTRIES];
  logic [ITEM_WIDTH-1:0] rd_data_r;
  logic                  stb_r;
  cmd_t                  res_r;

  // Commands run in order, so a word written here is visible to any later read.
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd.wr) begin
      mem[cmd.addr] <= cmd.data;
    end
    if (cmd_valid) begin
      rd_data_r <= mem[cmd.addr];
      res_r     <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stb_r <= 1'b0;
    end else begin
      stb_r <= cmd_valid;
    end
  end

  assign out_strobe      = stb_r;
  assign out_item_out    = res_r.rd ? from_item(rd_data_r) : '0;
  assign out_item_valid  = res_r.rd;
  assign out_overflow    = res_r.overflow;
  assign out_total_count = res_r.total;
  assign out_is_empty    = res_r.empty;

  a_valid_not_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_item_valid && out_overflow))
    else $error("result carries both a returned word and an overflow");

endmodule
